// ----- rtl/depq_pkg.sv -----
package depq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int OP_W     = 2;
  localparam int OCC_W    = 7;
  localparam int STAT_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT     = 2'd0,
    OP_REMOVE_MAX = 2'd1,
    OP_REMOVE_MIN = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                     load;
    logic signed [DATA_W-1:0] sample;
    logic signed [DATA_W-1:0] cur_max;
    logic signed [DATA_W-1:0] cur_min;
  } mm_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_max;
    logic signed [DATA_W-1:0] new_min;
  } mm_rsp_t;

endpackage

// ----- rtl/depq_in_if.sv -----
interface depq_in_if import depq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

// ----- rtl/depq_out_if.sv -----
interface depq_out_if import depq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] largest;
  logic signed [DATA_W-1:0] smallest;
  logic [OCC_W-1:0]         occupancy;
  logic [STAT_W-1:0]        status;

  modport source (output valid, output largest, output smallest, output occupancy,
                  output status, input ready);
  modport sink   (input valid, input largest, input smallest, input occupancy,
                  input status, output ready);
endinterface

// ----- rtl/double_ended_priority_queue_unit.sv -----
// Channel   Dir  Handshake    Payload
// in_item   in   valid/ready  operation[1:0], value[31:0] signed
// out_item  out  valid/ready  largest, smallest [31:0] signed, occupancy[6:0], status[1:0]
//
// Insert, ignored removal and unused op: idle goes straight to S_DONE to post the result.
// Removal: the single read port of the store walks one entry per cycle, first to
// locate the extreme, then over all n-1 remaining entries to rebuild largest/smallest.
// Reset clears the count and the sequencer; the store itself is not cleared.
// in_item.ready is high only while idle; a finished result waits for out_item.ready.
module double_ended_priority_queue_unit import depq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  depq_in_if.sink     in_item,
  depq_out_if.source  out_item
);

  typedef enum logic [2:0] {S_IDLE, S_FIND, S_MOVE, S_ISSUE, S_SCAN, S_DONE} state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic signed [DATA_W-1:0] max_r, max_nxt;
  logic signed [DATA_W-1:0] min_r, min_nxt;
  logic signed [DATA_W-1:0] target_r, target_nxt;
  logic [IDX_W-1:0]         addr_r, addr_nxt;
  logic [IDX_W-1:0]         hole_r, hole_nxt;
  status_t                  status_r, status_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_largest_r, out_largest_nxt;
  logic signed [DATA_W-1:0] out_smallest_r, out_smallest_nxt;
  logic [OCC_W-1:0]         out_occ_r, out_occ_nxt;
  status_t                  out_status_r, out_status_nxt;

  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rd_data_r;
  logic [IDX_W-1:0]         rd_addr;
  logic                     we;
  logic [IDX_W-1:0]         wa;
  logic signed [DATA_W-1:0] wd;

  logic                     in_fire;
  logic [IDX_W-1:0]         last_idx;
  mm_req_t                  mm_req;
  mm_rsp_t                  mm_rsp;

  assign in_item.ready     = (state_r == S_IDLE);
  assign in_fire           = in_item.valid && in_item.ready;
  assign last_idx          = IDX_W'(count_r - CNT_W'(1));

  assign out_item.valid     = out_valid_r;
  assign out_item.largest   = out_largest_r;
  assign out_item.smallest  = out_smallest_r;
  assign out_item.occupancy = out_occ_r;
  assign out_item.status    = out_status_r;

  // shared extreme tracker: scan samples or the inserted value
  always_comb begin
    mm_req.cur_max = max_r;
    mm_req.cur_min = min_r;
    if (state_r == S_SCAN) begin
      mm_req.sample = rd_data_r;
      mm_req.load   = (addr_r == '0);
    end else begin
      mm_req.sample = in_item.value;
      mm_req.load   = (count_r == '0);
    end
  end

  depq_minmax u_minmax (
    .req (mm_req),
    .rsp (mm_rsp)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    max_nxt          = max_r;
    min_nxt          = min_r;
    target_nxt       = target_r;
    addr_nxt         = addr_r;
    hole_nxt         = hole_r;
    status_nxt       = status_r;
    out_valid_nxt    = out_valid_r;
    out_largest_nxt  = out_largest_r;
    out_smallest_nxt = out_smallest_r;
    out_occ_nxt      = out_occ_r;
    out_status_nxt   = out_status_r;
    rd_addr          = addr_r;
    we               = 1'b0;
    wa               = hole_r;
    wd               = rd_data_r;

    if (out_valid_r && out_item.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          status_nxt = ST_DONE;
          state_nxt  = S_DONE;
          case (op_t'(in_item.operation))
            OP_INSERT: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                we        = 1'b1;
                wa        = IDX_W'(count_r);
                wd        = in_item.value;
                max_nxt   = mm_rsp.new_max;
                min_nxt   = mm_rsp.new_min;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_REMOVE_MAX, OP_REMOVE_MIN: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                target_nxt = (op_t'(in_item.operation) == OP_REMOVE_MAX) ? max_r : min_r;
                rd_addr    = '0;
                addr_nxt   = '0;
                state_nxt  = S_FIND;
              end
            end
            default: begin
              status_nxt = ST_DONE;
            end
          endcase
        end
      end
      S_FIND: begin
        if (rd_data_r == target_r) begin
          hole_nxt  = addr_r;
          rd_addr   = last_idx;
          state_nxt = S_MOVE;
        end else begin
          addr_nxt = addr_r + IDX_W'(1);
          rd_addr  = addr_r + IDX_W'(1);
        end
      end
      S_MOVE: begin
        // last entry fills the hole
        we        = 1'b1;
        wa        = hole_r;
        wd        = rd_data_r;
        count_nxt = count_r - CNT_W'(1);
        state_nxt = (count_r == CNT_W'(1)) ? S_DONE : S_ISSUE;
      end
      S_ISSUE: begin
        rd_addr   = '0;
        addr_nxt  = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        max_nxt = mm_rsp.new_max;
        min_nxt = mm_rsp.new_min;
        if (addr_r == last_idx) begin
          state_nxt = S_DONE;
        end else begin
          addr_nxt = addr_r + IDX_W'(1);
          rd_addr  = addr_r + IDX_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_item.ready) begin
          out_valid_nxt    = 1'b1;
          out_largest_nxt  = (count_r == '0) ? '0 : max_r;
          out_smallest_nxt = (count_r == '0) ? '0 : min_r;
          out_occ_nxt      = OCC_W'(count_r);
          out_status_nxt   = status_r;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= ST_DONE;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
    max_r          <= max_nxt;
    min_r          <= min_nxt;
    target_r       <= target_nxt;
    addr_r         <= addr_nxt;
    hole_r         <= hole_nxt;
    out_largest_r  <= out_largest_nxt;
    out_smallest_r <= out_smallest_nxt;
    out_occ_r      <= out_occ_nxt;
    out_status_r   <= out_status_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count exceeds capacity");

  a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid && out_item.status == ST_EMPTY |->
      out_item.occupancy == '0 && out_item.largest == '0 && out_item.smallest == '0)
    else $error("empty removal reported nonzero contents");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && op_t'(in_item.operation) == OP_INSERT && count_r != CNT_W'(CAPACITY)
      |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not advance count");

  a_move_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MOVE |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("removal did not reduce count");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN || state_r == S_FIND |-> count_r != '0)
    else $error("store walk with empty queue");
`endif

endmodule

// ----- rtl/depq_minmax.sv -----
module depq_minmax import depq_pkg::*; (
  input  mm_req_t req,
  output mm_rsp_t rsp
);

  always_comb begin
    if (req.load) begin
      rsp.new_max = req.sample;
      rsp.new_min = req.sample;
    end else begin
      rsp.new_max = (req.sample > req.cur_max) ? req.sample : req.cur_max;
      rsp.new_min = (req.sample < req.cur_min) ? req.sample : req.cur_min;
    end
  end

endmodule
